// ----- rtl/core/tcw_pkg.sv -----
`timescale 1ns / 1ps
// Types, codes and cell helpers shared by the text console writer core.
package tcw_pkg;

   localparam logic [1:0] CMD_PUT   = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_TAB       = 8'd9;
   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_RETURN    = 8'd13;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_PRINT_MIN = 8'd32;

   localparam int TAB_STOP = 8;

   localparam logic [3:0] RESET_FG = 4'hF;
   localparam logic [3:0] RESET_BG = 4'h0;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  char_code;
      logic [3:0]  clear_background;
      logic [10:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [6:0]  cursor_column;
      logic [4:0]  cursor_row;
      logic [10:0] cursor_position;
      logic [15:0] read_data;
   } rsp_type;

   function automatic logic [15:0] make_cell(input logic [7:0] ch, input logic [3:0] fg,
                                             input logic [3:0] bg);
      make_cell = {bg, fg, ch};
   endfunction

endpackage

// ----- rtl/core/tcw_cell_ram.sv -----
`timescale 1ns / 1ps
// Screen cell store: one write port, one registered read port.
module tcw_cell_ram #(
   parameter int DEPTH = 2000,
   parameter int AW    = 11
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [15:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [15:0]   rd_data
);

   logic [15:0] mem [DEPTH];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/text_console_char_writer_core.sv -----
`timescale 1ns / 1ps
// Text console writer: cursor control, scroll and clear sequencer around the cell store.
//
// After reset the core is busy while it blanks the cell store one cell per
// cycle; configuration writes are taken throughout. A put that does not
// scroll, and an unused command, go from accept through the response state
// back to idle, the result strobe showing as idle returns. A read also passes
// a read state, set by the registered read of the store. A clear, and a put
// that scrolls, sweep every cell first: the single write port of the store
// moves or blanks one cell per cycle. The result strobe lasts one cycle and
// cannot be held off; a new command may be started in that same cycle.
module text_console_char_writer_core
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_strobe,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [3:0] csr_data
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int XW    = $clog2(COLUMNS + TAB_STOP);
   localparam int YW    = $clog2(ROWS + 1);

   localparam logic [AW-1:0] COL_A  = AW'(COLUMNS);
   localparam logic [AW-1:0] MOVE_A = AW'((ROWS - 1) * COLUMNS);
   localparam logic [AW-1:0] LAST_A = AW'(CELLS - 1);
   localparam logic [XW-1:0] COL_X  = XW'(COLUMNS);
   localparam logic [YW-1:0] ROW_Y  = YW'(ROWS);
   localparam logic [YW-1:0] LAST_Y = YW'(ROWS - 1);

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_DRAIN,
      ST_IDLE,
      ST_READ,
      ST_RESP
   } state_type;

   state_type     state_ff;
   logic [XW-1:0] x_ff;
   logic [YW-1:0] y_ff;
   logic [3:0]    bg_ff;
   logic [3:0]    fg_ff;
   logic [AW-1:0] cnt_ff;
   logic          copy_ff;
   logic          report_ff;
   logic [15:0]   blank_ff;
   logic          pend_ff;
   logic [AW-1:0] pend_addr_ff;
   logic          pend_copy_ff;
   logic          rd_ok_ff;
   logic [15:0]   data_ff;
   logic          rsp_strobe_ff;
   rsp_type       rsp_data_ff;

   logic [XW-1:0] put_x;
   logic [YW-1:0] put_y;
   logic          put_wr;
   logic          put_scroll;
   logic          accept;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [15:0]   mem_wdata;
   logic [AW-1:0] mem_raddr;
   logic [15:0]   mem_rdata;
   logic [AW-1:0] cursor_addr;

   assign accept      = start && (state_ff == ST_IDLE);
   assign busy        = (state_ff != ST_IDLE);
   assign csr_ready   = 1'b1;
   assign cursor_addr = AW'(32'(y_ff) * COLUMNS + 32'(x_ff));

   always_comb begin
      put_x  = x_ff;
      put_y  = y_ff;
      put_wr = 1'b0;
      case (req_data.char_code)
         CH_BACKSPACE: begin
            if (x_ff != '0) begin
               put_x = x_ff - XW'(1);
            end
         end
         CH_TAB: begin
            put_x = (x_ff + XW'(TAB_STOP)) & ~XW'(TAB_STOP - 1);
         end
         CH_RETURN: begin
            put_x = '0;
         end
         CH_NEWLINE: begin
            put_x = '0;
            put_y = y_ff + YW'(1);
         end
         default: begin
            if (req_data.char_code >= CH_PRINT_MIN) begin
               put_wr = 1'b1;
               put_x  = x_ff + XW'(1);
            end
         end
      endcase
      if (put_x >= COL_X) begin
         put_x = '0;
         put_y = put_y + YW'(1);
      end
      put_scroll = (put_y >= ROW_Y);
   end

   // store ports: direct write for a printed char, pipelined write behind sweep reads
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = pend_addr_ff;
      mem_wdata = pend_copy_ff ? mem_rdata : blank_ff;
      mem_raddr = AW'(req_data.cell_index);
      if (state_ff == ST_SWEEP) begin
         mem_raddr = cnt_ff + COL_A;
      end
      if (accept && (req_data.command == CMD_PUT) && put_wr) begin
         mem_we    = 1'b1;
         mem_waddr = cursor_addr;
         mem_wdata = make_cell(req_data.char_code, fg_ff, bg_ff);
      end else if (pend_ff) begin
         mem_we = 1'b1;
      end
   end

   tcw_cell_ram #(
      .DEPTH (CELLS),
      .AW    (AW)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         x_ff          <= '0;
         y_ff          <= '0;
         bg_ff         <= RESET_BG;
         fg_ff         <= RESET_FG;
         cnt_ff        <= '0;
         copy_ff       <= 1'b0;
         report_ff     <= 1'b0;
         blank_ff      <= make_cell(CH_SPACE, RESET_FG, RESET_BG);
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         pend_ff       <= 1'b0;
         if (csr_valid && csr_ready) begin
            fg_ff <= csr_data;
         end
         case (state_ff)
            ST_SWEEP: begin
               pend_ff      <= 1'b1;
               pend_addr_ff <= cnt_ff;
               pend_copy_ff <= copy_ff && (cnt_ff < MOVE_A);
               if (cnt_ff == LAST_A) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  cnt_ff <= cnt_ff + AW'(1);
               end
            end
            ST_DRAIN: begin
               state_ff <= report_ff ? ST_RESP : ST_IDLE;
            end
            ST_IDLE: begin
               if (start) begin
                  data_ff  <= '0;
                  rd_ok_ff <= (32'(req_data.cell_index) < CELLS);
                  state_ff <= ST_RESP;
                  case (req_data.command)
                     CMD_PUT: begin
                        if (put_scroll) begin
                           x_ff      <= '0;
                           y_ff      <= LAST_Y;
                           blank_ff  <= make_cell(CH_SPACE, fg_ff, bg_ff);
                           cnt_ff    <= '0;
                           copy_ff   <= 1'b1;
                           report_ff <= 1'b1;
                           state_ff  <= ST_SWEEP;
                        end else begin
                           x_ff <= put_x;
                           y_ff <= put_y;
                        end
                     end
                     CMD_CLEAR: begin
                        x_ff      <= '0;
                        y_ff      <= '0;
                        bg_ff     <= req_data.clear_background;
                        blank_ff  <= make_cell(CH_SPACE, fg_ff, req_data.clear_background);
                        cnt_ff    <= '0;
                        copy_ff   <= 1'b0;
                        report_ff <= 1'b1;
                        state_ff  <= ST_SWEEP;
                     end
                     CMD_READ: begin
                        state_ff <= ST_READ;
                     end
                     default: begin
                        state_ff <= ST_RESP;
                     end
                  endcase
               end
            end
            ST_READ: begin
               data_ff  <= rd_ok_ff ? mem_rdata : '0;
               state_ff <= ST_RESP;
            end
            ST_RESP: begin
               rsp_strobe_ff               <= 1'b1;
               rsp_data_ff.cursor_column   <= 7'(x_ff);
               rsp_data_ff.cursor_row      <= 5'(y_ff);
               rsp_data_ff.cursor_position <= 11'(cursor_addr);
               rsp_data_ff.read_data       <= data_ff;
               state_ff                    <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule
